// ===== src/pth_pkg.sv =====
package pth_pkg;

    localparam int COORD_W   = 16;
    localparam int COEF_W    = 16;
    localparam int NROW      = 4;
    localparam int NCOL      = 4;
    localparam int NLANE     = 3;
    localparam int PROD_W    = COORD_W + COEF_W;
    localparam int TRANS_SH  = 8;
    localparam int SUM_W     = PROD_W + 2;
    localparam int ABS_W     = SUM_W;
    localparam int DIV_SH    = 9;
    localparam int NUM_W     = ABS_W + DIV_SH;
    localparam int Q_W       = 18;
    localparam int OVF_W     = ABS_W + Q_W;
    localparam int CMP_W     = ABS_W + Q_W - 1;

    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_3 = 2'd3;

    localparam logic [CFG_W-1:0] ROW_RESET  = '0;
    localparam logic [CFG_W-1:0] ROW3_RESET = 64'd4096;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
    localparam logic [Q_W-1:0] POS_LIMIT = 18'd32767;
    localparam logic [Q_W-1:0] NEG_LIMIT = 18'd32768;

    typedef struct packed {
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
        logic signed [COORD_W-1:0] in_z;
    } in_beat_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      w_zero;
        logic                      clipped;
    } out_beat_t;

    typedef struct packed {
        logic             valid;
        logic             w_zero;
        logic [NLANE-1:0] neg;
        logic [NLANE-1:0] ovf;
    } pth_side_t;

endpackage

// ===== src/point_transform_homogeneous.sv =====
// channel  | handshake                    | payload
// ---------+------------------------------+--------------------------------------
// in       | in_valid / in_ready          | in_data  (in_x, in_y, in_z)
// out      | out_valid / out_ready        | out_data (out_x, out_y, out_z, w_zero,
//          |                              |           clipped)
// cfg      | cfg_we                       | cfg_index, cfg_data
//
// One beat per cycle while the output is not held; stages: multiply, row sum, magnitude, range
// check, an 18-stage restoring divider (one quotient bit per stage), output.
// Reset clears all valid bits and loads w = x into the w row.
// A held output beat freezes the whole pipeline; in_ready follows it.
module point_transform_homogeneous
    import pth_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_beat_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_beat_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0] row_reg [NROW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW_RESET;
            row_reg[1] <= ROW_RESET;
            row_reg[2] <= ROW_RESET;
            row_reg[3] <= ROW3_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_0: row_reg[0] <= cfg_data;
                REG_ROW_1: row_reg[1] <= cfg_data;
                REG_ROW_2: row_reg[2] <= cfg_data;
                REG_ROW_3: row_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic out_vld_reg;

    assign en        = !out_vld_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_vld_reg;

    // stage 1: products
    logic signed [COORD_W-1:0] crd [NLANE];
    logic signed [COEF_W-1:0]  coef [NROW][NCOL];
    logic                      vld1_reg;
    logic signed [PROD_W-1:0]  prod_reg [NROW][NLANE];
    logic signed [COEF_W-1:0]  trans_reg [NROW];

    assign crd[0] = in_data.in_x;
    assign crd[1] = in_data.in_y;
    assign crd[2] = in_data.in_z;

    always_comb
    begin
        for (int r = 0; r < NROW; r++)
        begin
            for (int c = 0; c < NCOL; c++)
            begin
                coef[r][c] = $signed(row_reg[r][COEF_W*c +: COEF_W]);
            end
        end
    end

    // stage 2: row sums, stage 3: magnitudes, stage 4: divider setup
    logic                     vld2_reg;
    logic signed [SUM_W-1:0]  sum_reg [NROW];
    logic                     vld3_reg;
    logic [ABS_W-1:0]         abs_reg [NROW];
    logic [NROW-1:0]          sgn_reg;
    logic                     wz3_reg;
    pth_side_t                side4_reg;
    logic [ABS_W-1:0]         den4_reg;
    logic [NLANE-1:0][NUM_W-1:0] num4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg  <= 1'b0;
            vld2_reg  <= 1'b0;
            vld3_reg  <= 1'b0;
            side4_reg <= '0;
        end
        else if (en)
        begin
            vld1_reg         <= in_valid;
            vld2_reg         <= vld1_reg;
            vld3_reg         <= vld2_reg;
            side4_reg.valid  <= vld3_reg;
            side4_reg.w_zero <= wz3_reg;
            for (int l = 0; l < NLANE; l++)
            begin
                side4_reg.neg[l] <= sgn_reg[l] ^ sgn_reg[NROW-1];
                side4_reg.ovf[l] <= OVF_W'({abs_reg[l], {DIV_SH{1'b0}}})
                                    >= (OVF_W'(abs_reg[NROW-1]) << Q_W);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < NROW; r++)
            begin
                for (int c = 0; c < NLANE; c++)
                begin
                    prod_reg[r][c] <= coef[r][c] * crd[c];
                end
                trans_reg[r] <= coef[r][NCOL-1];
                sum_reg[r] <= SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                            + SUM_W'(prod_reg[r][2]) + (SUM_W'(trans_reg[r]) <<< TRANS_SH);
                sgn_reg[r] <= sum_reg[r][SUM_W-1];
                abs_reg[r] <= sum_reg[r][SUM_W-1] ? ABS_W'(-sum_reg[r])
                                                  : ABS_W'(sum_reg[r]);
            end
            wz3_reg  <= sum_reg[NROW-1] == '0;
            den4_reg <= abs_reg[NROW-1];
            for (int l = 0; l < NLANE; l++)
            begin
                num4_reg[l] <= {abs_reg[l], {DIV_SH{1'b0}}};
            end
        end
    end

    pth_side_t                 div_side;
    logic [NLANE-1:0][Q_W-1:0] div_quo;

    pth_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .side_in  (side4_reg),
        .den      (den4_reg),
        .num      (num4_reg),
        .side_out (div_side),
        .quo      (div_quo)
    );

    // quotient is floor(2n/d); round half away from zero, then saturate
    logic signed [COORD_W-1:0] res [NLANE];
    logic [NLANE-1:0]          sat;

    always_comb
    begin
        logic [Q_W:0]   inc;
        logic [Q_W-1:0] qr;
        for (int l = 0; l < NLANE; l++)
        begin
            inc = (Q_W+1)'(div_quo[l]) + (Q_W+1)'(1);
            qr  = inc[Q_W:1];
            if (div_side.neg[l])
            begin
                sat[l] = div_side.ovf[l] || (qr > NEG_LIMIT);
                res[l] = sat[l] ? COORD_MIN : COORD_W'(-qr);
            end
            else
            begin
                sat[l] = div_side.ovf[l] || (qr > POS_LIMIT);
                res[l] = sat[l] ? COORD_MAX : COORD_W'(qr);
            end
        end
    end

    out_beat_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= div_side.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (div_side.w_zero)
            begin
                out_data_reg.out_x   <= '0;
                out_data_reg.out_y   <= '0;
                out_data_reg.out_z   <= '0;
                out_data_reg.w_zero  <= 1'b1;
                out_data_reg.clipped <= 1'b0;
            end
            else
            begin
                out_data_reg.out_x   <= res[0];
                out_data_reg.out_y   <= res[1];
                out_data_reg.out_z   <= res[2];
                out_data_reg.w_zero  <= 1'b0;
                out_data_reg.clipped <= |sat;
            end
        end
    end

    assign out_data = out_data_reg;

    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    a_wzero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.w_zero |->
            out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_z == '0
            && !out_data.clipped)
        else $error("zero-w beat carries data");

    a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.clipped |->
            out_data.out_x == COORD_MAX || out_data.out_x == COORD_MIN
            || out_data.out_y == COORD_MAX || out_data.out_y == COORD_MIN
            || out_data.out_z == COORD_MAX || out_data.out_z == COORD_MIN)
        else $error("clipped beat without a saturated coordinate");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld1_reg)
        else $error("accepted beat lost at first stage");

endmodule

// ===== src/pth_div.sv =====
module pth_div
    import pth_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  pth_side_t                   side_in,
    input  logic [ABS_W-1:0]            den,
    input  logic [NLANE-1:0][NUM_W-1:0] num,
    output pth_side_t                   side_out,
    output logic [NLANE-1:0][Q_W-1:0]   quo
);

    // one quotient bit per stage, MSB first
    genvar s;
    generate
        for (s = 0; s < Q_W; s++)
        begin : g_stage
            localparam int B = Q_W - 1 - s;

            pth_side_t                   side_reg;
            logic [ABS_W-1:0]            den_reg;
            logic [NLANE-1:0][NUM_W-1:0] rem_reg;
            logic [NLANE-1:0][Q_W-1:0]   quo_reg;

            pth_side_t                   side_s;
            logic [ABS_W-1:0]            den_s;
            logic [NLANE-1:0][NUM_W-1:0] rem_s;
            logic [NLANE-1:0][Q_W-1:0]   quo_s;
            logic [NLANE-1:0][NUM_W-1:0] rem_next;
            logic [NLANE-1:0][Q_W-1:0]   quo_next;
            logic [CMP_W-1:0]            dsh;

            if (s == 0)
            begin : g_first
                assign side_s = side_in;
                assign den_s  = den;
                assign rem_s  = num;
                assign quo_s  = '0;
            end
            else
            begin : g_rest
                assign side_s = g_stage[s-1].side_reg;
                assign den_s  = g_stage[s-1].den_reg;
                assign rem_s  = g_stage[s-1].rem_reg;
                assign quo_s  = g_stage[s-1].quo_reg;
            end

            assign dsh = CMP_W'(den_s) << B;

            always_comb
            begin
                logic ge;
                for (int l = 0; l < NLANE; l++)
                begin
                    ge = CMP_W'(rem_s[l]) >= dsh;
                    rem_next[l] = ge ? NUM_W'(CMP_W'(rem_s[l]) - dsh) : rem_s[l];
                    quo_next[l] = {quo_s[l][Q_W-2:0], ge};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    side_reg <= '0;
                end
                else if (en)
                begin
                    side_reg <= side_s;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg <= den_s;
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                end
            end
        end
    endgenerate

    assign side_out = g_stage[Q_W-1].side_reg;
    assign quo      = g_stage[Q_W-1].quo_reg;

endmodule

// ===== bench/point_transform_homogeneous_tb.sv =====
`timescale 1ns / 1ps

module point_transform_homogeneous_tb;
    import pth_pkg::*;

    localparam shortint UNIT_Q12 = 16'sd4096;

    class point_scoreboard;
        logic [CFG_W-1:0] rows [NROW];
        out_beat_t projected_q [$];
        int errors;

        function new();
            rows[0] = ROW_RESET;
            rows[1] = ROW_RESET;
            rows[2] = ROW_RESET;
            rows[3] = ROW3_RESET;
            errors = 0;
        endfunction

        function void load_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            rows[idx] = val;
        endfunction

        function int pending();
            return projected_q.size();
        endfunction

        function longint coef(int r, int c);
            shortint s;
            s = rows[r][16*c +: 16];
            return s;
        endfunction

        // dot product with (x, y, z, 1), units of 2^-20
        function longint row_dot(int r, in_beat_t p);
            return coef(r, 0) * p.in_x + coef(r, 1) * p.in_y + coef(r, 2) * p.in_z
                 + coef(r, 3) * 256;
        endfunction

        // round(num * 256 / den), ties away from zero, saturated to Q8.8
        function logic [COORD_W-1:0] divide_sat(longint num, longint den, inout bit sat);
            bit neg;
            longint unsigned n;
            longint unsigned d;
            longint unsigned q;
            longint r;
            neg = (num < 0) != (den < 0);
            n = (num < 0 ? -num : num);
            n = n * 256;
            d = (den < 0 ? -den : den);
            q = (2 * n + d) / (2 * d);
            if (neg) begin
                if (q > 64'd32768) begin
                    sat = 1'b1;
                    r = COORD_MIN;
                end
                else r = -longint'(q);
            end
            else begin
                if (q > 64'd32767) begin
                    sat = 1'b1;
                    r = COORD_MAX;
                end
                else r = longint'(q);
            end
            return r[COORD_W-1:0];
        endfunction

        function void note_point(in_beat_t p);
            out_beat_t want;
            longint w;
            bit sat;
            w = row_dot(3, p);
            sat = 1'b0;
            want = '0;
            if (w == 0) begin
                want.w_zero = 1'b1;
            end
            else begin
                want.out_x = divide_sat(row_dot(0, p), w, sat);
                want.out_y = divide_sat(row_dot(1, p), w, sat);
                want.out_z = divide_sat(row_dot(2, p), w, sat);
                want.clipped = sat;
            end
            projected_q.push_back(want);
        endfunction

        function void compare(string field, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
                errors++;
            end
        endfunction

        function void check_beat(out_beat_t got);
            out_beat_t want;
            if (projected_q.size() == 0) begin
                $error("output beat with no point pending: %h", got);
                errors++;
                return;
            end
            want = projected_q.pop_front();
            compare("out_x", want.out_x, got.out_x);
            compare("out_y", want.out_y, got.out_y);
            compare("out_z", want.out_z, got.out_z);
            compare("w_zero", COORD_W'(want.w_zero), COORD_W'(got.w_zero));
            compare("clipped", COORD_W'(want.clipped), COORD_W'(got.clipped));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_beat_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_beat_t            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    point_scoreboard sb;
    int send_calm;
    int recv_calm;

    point_transform_homogeneous dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_point(in_data);
        if (rst_n && out_valid && out_ready)
            sb.check_beat(out_data);
    end

    // idle cycles before a beat; occasional stretches with none
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [CFG_W-1:0] mk_row(shortint c0, shortint c1, shortint c2,
                                                shortint c3);
        return {c3, c2, c1, c0};
    endfunction

    function automatic shortint rand_coef(int span);
        return shortint'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic shortint extreme_coef();
        case ($urandom_range(0, 4))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return 16'sd0;
            3: return UNIT_Q12;
            default: return -UNIT_Q12;
        endcase
    endfunction

    function automatic int pick_coord();
        int k;
        k = $urandom_range(0, 19);
        if (k < 10)
            return $signed(COORD_W'($urandom));
        if (k < 14)
            return $urandom_range(0, 1024) - 512;
        case ($urandom_range(0, 6))
            0: return 0;
            1: return 1;
            2: return -1;
            3: return COORD_MAX;
            4: return COORD_MIN;
            5: return 256;
            default: return -256;
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_point(int x, int y, int z);
        int gap;
        in_beat_t p;
        p.in_x = COORD_W'(x);
        p.in_y = COORD_W'(y);
        p.in_z = COORD_W'(z);
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic load_matrix(logic [CFG_W-1:0] r0, logic [CFG_W-1:0] r1,
                               logic [CFG_W-1:0] r2, logic [CFG_W-1:0] r3);
        logic [CFG_W-1:0]     vals [NROW];
        logic [CFG_IDX_W-1:0] regs [NROW];
        vals = '{r0, r1, r2, r3};
        regs = '{REG_ROW_0, REG_ROW_1, REG_ROW_2, REG_ROW_3};
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
        for (int i = 0; i < NROW; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            sb.load_row(regs[i], vals[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int kind, int count);
        logic [CFG_W-1:0] r [NROW];
        for (int i = 0; i < NROW; i++)
        begin
            for (int c = 0; c < NCOL; c++)
            begin
                case (kind)
                    0: r[i][16*c +: 16] = (c == 3) ? rand_coef(32768) : rand_coef(2048);
                    1: r[i][16*c +: 16] = rand_coef(8192);
                    2: r[i][16*c +: 16] = 16'($urandom);
                    3: r[i][16*c +: 16] = extreme_coef();
                    default: r[i][16*c +: 16] = (i == 3) ? rand_coef(256) : 16'($urandom);
                endcase
            end
            if (i < 3 && kind <= 1)
                r[i][16*i +: 16] = r[i][16*i +: 16] + UNIT_Q12;
        end
        case (kind)
            0: r[3] = mk_row(0, 0, 0, UNIT_Q12);
            1: r[3] = mk_row(0, 0, UNIT_Q12, 0);
            4: r[3][63:48] = UNIT_Q12;
            default: ;
        endcase
        load_matrix(r[0], r[1], r[2], r[3]);
        repeat (count) send_point(pick_coord(), pick_coord(), pick_coord());
    endtask

    initial
    begin
        out_ready = 1'b0;
        recv_calm = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            int stall;
            stall = draw_wait(recv_calm);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        int kinds [7];
        kinds = '{0, 1, 2, 3, 1, 4, 0};
        sb = new();
        send_calm = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_ROW_0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset matrix: w = x, zero numerators
        send_point(0, 5, -7);
        send_point(256, 0, 0);
        send_point(-256, 100, 100);
        send_point(COORD_MAX, COORD_MIN, 1);
        send_point(COORD_MIN, COORD_MAX, -1);
        send_point(1, 1, 1);

        // identity, w exactly one
        load_matrix(mk_row(UNIT_Q12, 0, 0, 0), mk_row(0, UNIT_Q12, 0, 0),
                    mk_row(0, 0, UNIT_Q12, 0), mk_row(0, 0, 0, UNIT_Q12));
        send_point(COORD_MAX, COORD_MIN, 0);
        send_point(COORD_MIN, COORD_MAX, -1);
        send_point(16'h5555, 16'hAAAA, 16'h0F0F);
        send_point(-16'sh0F0F, 1, 256);

        // w = 2: rounding ties
        load_matrix(mk_row(UNIT_Q12, 0, 0, 0), mk_row(0, UNIT_Q12, 0, 0),
                    mk_row(0, 0, UNIT_Q12, 0), mk_row(0, 0, 0, shortint'(2 * UNIT_Q12)));
        send_point(1, -1, 3);
        send_point(-3, COORD_MAX, COORD_MIN);

        // w = 0.5: saturation and the exact negative limit
        load_matrix(mk_row(UNIT_Q12, 0, 0, 0), mk_row(0, UNIT_Q12, 0, 0),
                    mk_row(0, 0, UNIT_Q12, 0), mk_row(0, 0, 0, shortint'(UNIT_Q12 / 2)));
        send_point(COORD_MAX, COORD_MIN, -16384);
        send_point(16383, -16384, 100);

        // negative w
        load_matrix(mk_row(UNIT_Q12, 0, 0, 0), mk_row(0, UNIT_Q12, 0, 0),
                    mk_row(0, 0, UNIT_Q12, 0), mk_row(0, 0, 0, -UNIT_Q12));
        send_point(COORD_MIN, COORD_MAX, 5);
        send_point(100, -100, 0);

        // extreme coefficients
        load_matrix(mk_row(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX),
                    mk_row(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN),
                    mk_row(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN),
                    mk_row(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(0, 0, 0);

        foreach (kinds[i])
            random_phase(kinds[i], 100);

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
